// ----- sv/rtxt_pkg.sv -----
// Shared types and constants for the retransmit timeout table.
// Holds the stream payload layouts, the slot record layouts and the action codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtxt_pkg;

    localparam int SEQ_W     = 16;
    localparam int TIME_W    = 32;
    localparam int RETRY_W   = 16;
    localparam int RTT_W     = 16;
    localparam int LOSS_W    = 16;
    localparam int TIMEOUT_W = 34;

    localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

    typedef enum logic [1:0]
    {
        ACT_STORE = 2'd0,
        ACT_ACK   = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    // Input transfer payload; first field sits in the highest bits.
    typedef struct packed
    {
        logic [31:0]         ammo_word;
        logic [63:0]         stick_pair;
        logic [47:0]         control_word;
        logic [63:0]         name_high;
        logic [63:0]         name_low;
        logic [LOSS_W-1:0]   loss_fraction;
        logic [RTT_W-1:0]    round_trip;
        logic [TIME_W-1:0]   now;
        logic [SEQ_W-1:0]    sequence_req;
    } in_data_t;

    // Output transfer payload; first field sits in the highest bits.
    typedef struct packed
    {
        logic [31:0]         out_ammo_word;
        logic [63:0]         out_stick_pair;
        logic [47:0]         out_control_word;
        logic [63:0]         out_name_high;
        logic [63:0]         out_name_low;
        logic [RETRY_W-1:0]  retry_count;
        logic [SEQ_W-1:0]    resent_sequence;
    } out_data_t;

    // Slot bookkeeping, rewritten on every retransmission.
    typedef struct packed
    {
        logic [RETRY_W-1:0]  retries;
        logic [TIME_W-1:0]   sent_time;
        logic [SEQ_W-1:0]    sequence_no;
    } meta_t;

    // Slot payload, written only by a store.
    typedef struct packed
    {
        logic [31:0]         ammo;
        logic [63:0]         sticks;
        logic [47:0]         control;
        logic [63:0]         name_high;
        logic [63:0]         name_low;
    } pay_t;

endpackage

`default_nettype wire

// ----- sv/retransmit_timeout_table.sv -----
// Channel   Dir  Payload (tdata / tuser / tlast)                        Transfer
// s_axis    in   tdata: sequence_req..ammo_word, tuser: action          tvalid & tready
// m_axis    out  tdata: resent_sequence..out_ammo_word, tlast: last     tvalid & tready
//
// Store: accepted in idle, input stays ready. Ack: each slot scanned costs a read step and a check
// step, and the scan stops at the first match. Tick: every slot is scanned, then a flush step; each
// slot costs one registered memory read and one check, and a hit waits while both the held result
// and the output register are full.
// One result is held back so that the last of a tick can carry tlast.
// Reset empties every slot through the valid bits at once; no clearing pass.
//
// Retransmission buffer with slot ring, ack search and timeout scan.
// Depends on rtxt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module retransmit_timeout_table #(
    parameter int SLOTS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // sequence_req, now, round_trip, loss_fraction, name_low, name_high,
    // control_word, stick_pair, ammo_word
    input  wire logic [351:0] s_axis_tdata,
    // action
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // resent_sequence, retry_count, out_name_low, out_name_high,
    // out_control_word, out_stick_pair, out_ammo_word
    output logic [303:0]      m_axis_tdata,
    // last_of_tick
    output logic              m_axis_tlast
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    rtxt_pkg::in_data_t in_data;
    assign in_data = s_axis_tdata;

    // control state
    state_t                   state_reg, state_next;
    logic [SLOTS-1:0]         valid_reg, valid_next;
    logic [IDX_W-1:0]         write_slot_reg, write_slot_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     tick_op_reg, tick_op_next;
    logic                     held_valid_reg, held_valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_last_reg, out_last_next;

    // payload state
    logic [rtxt_pkg::SEQ_W-1:0]     seq_reg, seq_next;
    logic [rtxt_pkg::TIME_W-1:0]    now_reg, now_next;
    logic [rtxt_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;
    rtxt_pkg::out_data_t            held_reg, held_next;
    rtxt_pkg::out_data_t            out_reg, out_next;

    // slot memories
    rtxt_pkg::meta_t          meta_mem [SLOTS];
    rtxt_pkg::pay_t           pay_mem [SLOTS];
    rtxt_pkg::meta_t          meta_rd_reg;
    rtxt_pkg::pay_t           pay_rd_reg;
    logic                     meta_we;
    logic                     pay_we;
    logic [IDX_W-1:0]         meta_waddr;
    rtxt_pkg::meta_t          meta_wd;
    rtxt_pkg::pay_t           pay_wd;

    logic                     s_accept;
    logic                     out_free;
    logic [rtxt_pkg::SEQ_W-1:0]   eff_seq;
    logic [rtxt_pkg::TIME_W-1:0]  age;
    logic                     expired;
    logic                     hit;
    logic [rtxt_pkg::RETRY_W-1:0] retry_new;
    logic [32:0]              tmo_prod;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = out_last_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // rtt * (65536 + loss), both operands held in 33 bits
    assign tmo_prod = {17'b0, in_data.round_trip} * {16'b0, 1'b1, in_data.loss_fraction};

    assign eff_seq   = valid_reg[idx_reg] ? meta_rd_reg.sequence_no : '0;
    assign age       = now_reg - meta_rd_reg.sent_time;
    assign expired   = {age, 16'h0} > {14'h0, timeout_reg};
    assign hit       = (eff_seq != '0) && expired;
    assign retry_new = (meta_rd_reg.retries == rtxt_pkg::RETRY_MAX)
                     ? meta_rd_reg.retries : meta_rd_reg.retries + 1'b1;

    assign pay_wd.name_low  = in_data.name_low;
    assign pay_wd.name_high = in_data.name_high;
    assign pay_wd.control   = in_data.control_word;
    assign pay_wd.sticks    = in_data.stick_pair;
    assign pay_wd.ammo      = in_data.ammo_word;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        write_slot_next = write_slot_reg;
        idx_next        = idx_reg;
        tick_op_next    = tick_op_reg;
        held_valid_next = held_valid_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        seq_next        = seq_reg;
        now_next        = now_reg;
        timeout_next    = timeout_reg;
        held_next       = held_reg;
        out_next        = out_reg;
        meta_we         = 1'b0;
        pay_we          = 1'b0;
        meta_waddr      = idx_reg;
        meta_wd         = meta_rd_reg;

        // drop the output once it is taken; a load below overrides
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (s_axis_tuser)
                        rtxt_pkg::ACT_STORE:
                        begin
                            meta_we                     = 1'b1;
                            pay_we                      = 1'b1;
                            meta_waddr                  = write_slot_reg;
                            meta_wd.sequence_no         = in_data.sequence_req;
                            meta_wd.sent_time           = in_data.now;
                            meta_wd.retries             = '0;
                            valid_next[write_slot_reg]  = 1'b1;
                            write_slot_next = (write_slot_reg == LAST_IDX)
                                            ? '0 : write_slot_reg + 1'b1;
                        end
                        rtxt_pkg::ACT_ACK:
                        begin
                            seq_next     = in_data.sequence_req;
                            idx_next     = '0;
                            tick_op_next = 1'b0;
                            state_next   = ST_READ;
                        end
                        rtxt_pkg::ACT_TICK:
                        begin
                            now_next     = in_data.now;
                            timeout_next = {tmo_prod, 1'b0};
                            idx_next     = '0;
                            tick_op_next = 1'b1;
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (!tick_op_reg)
                begin
                    if (eff_seq == seq_reg)
                    begin
                        valid_next[idx_reg] = 1'b0;
                        state_next          = ST_IDLE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (!(hit && held_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        meta_we           = 1'b1;
                        meta_wd.sent_time = now_reg;
                        meta_wd.retries   = retry_new;
                        if (held_valid_reg)
                        begin
                            out_next       = held_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        held_next.resent_sequence  = meta_rd_reg.sequence_no;
                        held_next.retry_count      = retry_new;
                        held_next.out_name_low     = pay_rd_reg.name_low;
                        held_next.out_name_high    = pay_rd_reg.name_high;
                        held_next.out_control_word = pay_rd_reg.control;
                        held_next.out_stick_pair   = pay_rd_reg.sticks;
                        held_next.out_ammo_word    = pay_rd_reg.ammo;
                        held_valid_next            = 1'b1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!held_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = held_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            write_slot_reg <= '0;
            idx_reg        <= '0;
            tick_op_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            write_slot_reg <= write_slot_next;
            idx_reg        <= idx_next;
            tick_op_reg    <= tick_op_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg     <= seq_next;
        now_reg     <= now_next;
        timeout_reg <= timeout_next;
        held_reg    <= held_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wd;
        end
        meta_rd_reg <= meta_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[write_slot_reg] <= pay_wd;
        end
        pay_rd_reg <= pay_mem[idx_reg];
    end

`ifndef SYNTH
    // a held result never survives past the end of a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !held_valid_reg)
        else $error("held result left over in idle");

    // at most one slot is filled or cleared per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) <= $countones($past(valid_reg)) + 1)
              && ($countones(valid_reg) + 1 >= $countones($past(valid_reg))))
        else $error("valid bits changed by more than one slot");

    // every store transfer advances the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_axis_tuser == rtxt_pkg::ACT_STORE)
        |=> (write_slot_reg != $past(write_slot_reg)))
        else $error("store did not advance write slot");

    // a tlast result is only loaded from the flush step
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_last_next && out_valid_next && !(out_valid_reg && out_last_reg))
        |-> (state_reg == ST_FLUSH))
        else $error("last result loaded outside flush");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for retransmit_timeout_table: stores, acks and timer ticks go in
// on the slave stream, and every retransmission out is compared with a local slot predictor.
// Depends on rtxt_pkg and retransmit_timeout_table.
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS        = 64;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;

    // Action code that the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct
    {
        logic [1:0]         act;
        rtxt_pkg::in_data_t data;
    } packet_cmd_t;

    typedef struct
    {
        rtxt_pkg::out_data_t data;
        logic                last;
    } resend_t;

    logic           clk           = 1'b0;
    logic           rst_n         = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [351:0]   s_axis_tdata  = '0;
    logic [1:0]     s_axis_tuser  = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [303:0]   m_axis_tdata;
    logic           m_axis_tlast;

    packet_cmd_t          cmd_q[$];
    packet_cmd_t          tx_cmd;
    resend_t              resend_q[$];
    resend_t              want;
    rtxt_pkg::out_data_t  got;

    // Predicted slot contents
    rtxt_pkg::meta_t      slot_meta[SLOTS];
    rtxt_pkg::pay_t       slot_pay[SLOTS];
    int             ring_ptr;

    int             queued_count   = 0;
    int             accepted_count = 0;
    int             mismatches     = 0;
    int             quiet_cycles   = 0;

    int             tx_gap;
    int             tx_burst;
    int             rx_wait;
    int             rx_burst;
    int             rx_draw;
    int             hold_left;
    logic           hold_request   = 1'b0;
    logic           hold_done;

    logic [31:0]    wall_ms;
    logic [15:0]    stored_seqs[$];

    retransmit_timeout_table #(
        .SLOTS(SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one accepted command to the slot predictor and queue the retransmissions it causes.
    task automatic apply_cmd(input logic [1:0] act, input rtxt_pkg::in_data_t d);
        logic [63:0] timeout;
        logic [31:0] age;
        resend_t     batch[$];
        resend_t     r;
        case (act)
            rtxt_pkg::ACT_STORE:
            begin
                slot_meta[ring_ptr].sequence_no = d.sequence_req;
                slot_meta[ring_ptr].sent_time   = d.now;
                slot_meta[ring_ptr].retries     = '0;
                slot_pay[ring_ptr].name_low     = d.name_low;
                slot_pay[ring_ptr].name_high    = d.name_high;
                slot_pay[ring_ptr].control      = d.control_word;
                slot_pay[ring_ptr].sticks       = d.stick_pair;
                slot_pay[ring_ptr].ammo         = d.ammo_word;
                ring_ptr = (ring_ptr + 1) % SLOTS;
            end
            rtxt_pkg::ACT_ACK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_meta[i].sequence_no == d.sequence_req)
                    begin
                        slot_meta[i].sequence_no = '0;
                        break;
                    end
                end
            end
            rtxt_pkg::ACT_TICK:
            begin
                // timeout in units of 1/65536 ms
                timeout = 64'd2 * 64'(d.round_trip) * (64'd65536 + 64'(d.loss_fraction));
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_meta[i].sequence_no != '0)
                    begin
                        age = d.now - slot_meta[i].sent_time;
                        if ({16'b0, age, 16'b0} > timeout)
                        begin
                            slot_meta[i].sent_time = d.now;
                            if (slot_meta[i].retries != rtxt_pkg::RETRY_MAX)
                                slot_meta[i].retries = slot_meta[i].retries + 1'b1;
                            r.data.resent_sequence  = slot_meta[i].sequence_no;
                            r.data.retry_count      = slot_meta[i].retries;
                            r.data.out_name_low     = slot_pay[i].name_low;
                            r.data.out_name_high    = slot_pay[i].name_high;
                            r.data.out_control_word = slot_pay[i].control;
                            r.data.out_stick_pair   = slot_pay[i].sticks;
                            r.data.out_ammo_word    = slot_pay[i].ammo;
                            r.last                  = 1'b0;
                            batch.push_back(r);
                        end
                    end
                end
                if (batch.size() != 0)
                    batch[batch.size() - 1].last = 1'b1;
                foreach (batch[k])
                    resend_q.push_back(batch[k]);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string label, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Sender: one transfer per command, random gap after each, occasional gap-free bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            tx_gap        <= 0;
            tx_burst      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (tx_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                tx_gap        <= tx_gap - 1;
            end
            else if (cmd_q.size() != 0)
            begin
                tx_cmd = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tx_cmd.data;
                s_axis_tuser  <= tx_cmd.act;
                if (tx_burst != 0)
                begin
                    tx_burst <= tx_burst - 1;
                    tx_gap   <= 0;
                end
                else
                begin
                    tx_gap <= $urandom_range(0, 15);
                    if ($urandom_range(0, 7) == 0)
                        tx_burst <= $urandom_range(8, 24);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random wait after each transfer, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
            rx_burst      <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            hold_done     <= 1'b1;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= (hold_left == 1);
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (rx_burst != 0)
            begin
                rx_burst      <= rx_burst - 1;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                rx_draw = $urandom_range(0, 15);
                rx_wait       <= rx_draw;
                m_axis_tready <= (rx_draw == 0);
                if ($urandom_range(0, 7) == 0)
                    rx_burst <= $urandom_range(8, 24);
            end
        end
        else if (rx_wait != 0)
        begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check outgoing transfers first, then predict from the incoming one.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (resend_q.size() == 0)
            begin
                $display("%0t: unexpected resend: expected none, actual seq %h last %b",
                         $time, got.resent_sequence, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = resend_q.pop_front();
                check_field("resent_sequence", want.data.resent_sequence, got.resent_sequence);
                check_field("retry_count", want.data.retry_count, got.retry_count);
                check_field("out_name_low", want.data.out_name_low, got.out_name_low);
                check_field("out_name_high", want.data.out_name_high, got.out_name_high);
                check_field("out_control_word", want.data.out_control_word,
                            got.out_control_word);
                check_field("out_stick_pair", want.data.out_stick_pair, got.out_stick_pair);
                check_field("out_ammo_word", want.data.out_ammo_word, got.out_ammo_word);
                check_field("last_of_tick", want.last, m_axis_tlast);
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            apply_cmd(s_axis_tuser, s_axis_tdata);
            accepted_count++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic rtxt_pkg::in_data_t scramble();
        rtxt_pkg::in_data_t d;
        d.sequence_req  = 16'($urandom);
        d.now           = $urandom;
        d.round_trip    = 16'($urandom);
        d.loss_fraction = 16'($urandom);
        d.name_low      = {$urandom, $urandom};
        d.name_high     = {$urandom, $urandom};
        d.control_word  = 48'({$urandom, $urandom});
        d.stick_pair    = {$urandom, $urandom};
        d.ammo_word     = $urandom;
        return d;
    endfunction

    task automatic offer(input logic [1:0] act, input rtxt_pkg::in_data_t d);
        packet_cmd_t c;
        c.act  = act;
        c.data = d;
        cmd_q.push_back(c);
        queued_count++;
    endtask

    task automatic offer_tick(input logic [31:0] now_ms, input logic [15:0] rtt,
                              input logic [15:0] loss);
        rtxt_pkg::in_data_t d;
        d               = scramble();
        d.now           = now_ms;
        d.round_trip    = rtt;
        d.loss_fraction = loss;
        offer(rtxt_pkg::ACT_TICK, d);
    endtask

    task automatic offer_store(input logic [15:0] seq, input logic [31:0] now_ms);
        rtxt_pkg::in_data_t d;
        d              = scramble();
        d.sequence_req = seq;
        d.now          = now_ms;
        stored_seqs.push_back(seq);
        if (stored_seqs.size() > SLOTS)
            void'(stored_seqs.pop_front());
        offer(rtxt_pkg::ACT_STORE, d);
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || resend_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly live traffic: stores from a small sequence pool, acks of stored
    // sequences, ticks with short timeouts. Ignored actions are extra noise.
    task automatic random_cmds(input int count);
        rtxt_pkg::in_data_t d;
        int          made;
        int          pick;
        int          sel;
        logic [15:0] seq;
        made = 0;
        while (made < count)
        begin
            d    = scramble();
            pick = $urandom_range(0, 99);
            if (pick < 48)
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    seq = '0;
                else if (sel < 5)
                    seq = 16'($urandom);
                else
                    seq = 16'($urandom_range(1, 48));
                offer_store(seq, wall_ms);
                made++;
            end
            else if (pick < 68)
            begin
                if (stored_seqs.size() != 0 && $urandom_range(0, 4) != 0)
                    d.sequence_req = stored_seqs[$urandom_range(0, stored_seqs.size() - 1)];
                offer(rtxt_pkg::ACT_ACK, d);
                made++;
            end
            else if (pick < 94)
            begin
                if ($urandom_range(0, 3) != 0)
                    d.round_trip = 16'($urandom_range(0, 40));
                offer_tick(wall_ms + $urandom_range(0, 100), d.round_trip, d.loss_fraction);
                made++;
            end
            else
            begin
                offer(ACT_UNUSED, d);
            end
            if ($urandom_range(0, 19) == 0)
                wall_ms = $urandom;
            else
                wall_ms = wall_ms + $urandom_range(0, 60);
        end
    endtask

    initial
    begin
        rtxt_pkg::in_data_t d;
        for (int i = 0; i < SLOTS; i++)
            slot_meta[i].sequence_no = '0;
        ring_ptr = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Tick on an empty table
        offer_tick(32'd0, 16'd0, 16'd0);
        // Store of sequence zero stays empty; all-ones and all-zeros payloads
        d = '1;
        d.sequence_req = '0;
        offer(rtxt_pkg::ACT_STORE, d);
        d = '1;
        d.now = 32'hFFFF_FFF0;
        offer(rtxt_pkg::ACT_STORE, d);
        d = '0;
        d.sequence_req = 16'd1;
        offer(rtxt_pkg::ACT_STORE, d);
        offer_store(16'h5555, 32'd100);
        offer_store(16'd1, 32'd200);
        // Ack of zero, ack with no match, ack of a duplicate clears the lowest slot
        d = scramble();
        d.sequence_req = '0;
        offer(rtxt_pkg::ACT_ACK, d);
        d.sequence_req = 16'h1234;
        offer(rtxt_pkg::ACT_ACK, d);
        d.sequence_req = 16'd1;
        offer(rtxt_pkg::ACT_ACK, d);
        // Zero timeout with wrapped ages, then zero age at zero timeout
        offer_tick(32'd16, 16'd0, 16'd0);
        offer_tick(32'd16, 16'd0, 16'hFFFF);
        // Largest timeout, with ages just short of it and just past it
        offer_tick(32'd16 + 32'd262138, 16'hFFFF, 16'hFFFF);
        offer_tick(32'd16 + 32'd262139, 16'hFFFF, 16'hFFFF);
        d = '1;
        offer(ACT_UNUSED, d);
        d = scramble();
        d.sequence_req = 16'hFFFF;
        offer(rtxt_pkg::ACT_ACK, d);
        offer_tick(32'hFFFF_FFFF, 16'd1, 16'd0);
        offer_store(16'hAAAA, 32'd5);
        offer_tick(32'd4, 16'hFFFF, 16'd0);
        wait_idle();

        wall_ms = $urandom;
        random_cmds(35);

        // Hold the receiver off while a full-table tick backs up into the input
        wait_idle();
        hold_request = 1'b1;
        repeat (12) offer_store(16'($urandom_range(1, 48)), wall_ms);
        offer_tick(wall_ms + 32'd5000, 16'd0, 16'($urandom));
        wall_ms = wall_ms + 32'd5000;
        random_cmds(10);
        wait_idle();

        random_cmds(30);

        while (accepted_count != queued_count || resend_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && resend_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
